// ===== src/wsc_pkg.sv =====
// Shared types and constants for the windowed spot centroid unit.
package wsc_pkg;

  // Input item kinds.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  // Fixed field widths.
  localparam int POS_W  = 17;
  localparam int ADDR_W = 18;
  localparam int VAL_W  = 16;
  localparam int DIM_W  = 10;
  localparam int RAD_W  = 6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the query and set up the window
    logic acc;        // accumulate one window pixel
    logic div_start;  // begin the two divisions
    logic div_step;   // one quotient bit
    logic finish;     // form the result
  } wsc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic win_done;   // last window pixel accumulated
    logic win_empty;  // window holds no pixel
    logic div_done;   // last quotient bit produced
  } wsc_sts_t;

endpackage

// ===== src/wsc_datapath.sv =====
// Datapath: frame memory, window walk, moment sums and serial division.
module wsc_datapath
  import wsc_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int PIXEL_BITS = 16,
  parameter int FRAC_BITS  = 8,
  parameter int MAX_RADIUS = 63
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  logic [VAL_W-1:0]    wr_value,
  input  logic [POS_W-1:0]    spot_x,
  input  logic [POS_W-1:0]    spot_y,
  input  logic [DIM_W-1:0]    frame_width,
  input  logic [DIM_W-1:0]    frame_height,
  input  logic [RAD_W-1:0]    radius,
  input  wsc_cmd_t            cmd,
  output wsc_sts_t            sts,
  output logic [POS_W-1:0]    res_x,
  output logic [POS_W-1:0]    res_y
);

  localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int SA_W   = $clog2(STORE_SIZE);
  localparam int CRD_W  = 14;                 // coordinates and window bounds
  localparam int MOM_W  = 48;
  localparam int WT_W   = 40;
  localparam int NUM_W  = MOM_W + FRAC_BITS;  // magnitude of scaled moment
  localparam int QCNT_W = $clog2(NUM_W + 1);
  localparam int RCLAMP = (MAX_RADIUS > 63) ? 63 : MAX_RADIUS;
  localparam int PROD_W = PIXEL_BITS + 1 + CRD_W;
  localparam logic signed [CRD_W-1:0] ONE_C = 1;

  // Frame memory, one write port and one registered read port.
  logic [PIXEL_BITS-1:0] mem [STORE_SIZE];
  logic [PIXEL_BITS-1:0] rd_data_r;
  logic [SA_W-1:0]       rd_addr;

  always_ff @(posedge clk) begin
    if (wr_en && ({14'd0, wr_addr} < 32'(STORE_SIZE)))
      mem[SA_W'(wr_addr)] <= wr_value[PIXEL_BITS-1:0];
    rd_data_r <= mem[rd_addr];
  end

  // Window registers.
  logic signed [CRD_W-1:0] h0_r, v0_r, lowh_r, high_r, higv_r, h_r, v_r;
  logic signed [CRD_W-1:0] h_nxt, v_nxt;
  logic [31:0]             row_base_r, row_base_nxt;
  // Pipeline stage between address and memory data.
  logic                    pv_r;
  logic signed [CRD_W-1:0] ph_r, pv_row_r;
  logic signed [MOM_W-1:0] cm_r, rm_r;
  logic [WT_W-1:0]         wt_r;
  logic signed [PROD_W-1:0] pcx, pcy;

  logic signed [CRD_W-1:0] rad, lh, hh, lv, hv, wm1, hm1;
  logic [31:0]             pos;
  logic                    in_store, last_pix;

  always_comb begin
    rad = (radius > RAD_W'(RCLAMP)) ? CRD_W'(RCLAMP) : CRD_W'(radius);
    lh  = $signed(CRD_W'(spot_x >> FRAC_BITS)) - rad;
    lv  = $signed(CRD_W'(spot_y >> FRAC_BITS)) - rad;
    if (lh < 0) lh = '0;
    if (lv < 0) lv = '0;
    wm1 = $signed(CRD_W'(frame_width)) - ONE_C;
    hm1 = $signed(CRD_W'(frame_height)) - ONE_C;
    hh  = $signed(CRD_W'(spot_x >> FRAC_BITS)) + rad;
    hv  = $signed(CRD_W'(spot_y >> FRAC_BITS)) + rad;
    if (hh > wm1) hh = wm1;
    if (hv > hm1) hv = hm1;
  end

  assign pos      = row_base_r + 32'($unsigned(h_r));
  assign in_store = pos < 32'(STORE_SIZE);
  assign rd_addr  = pos[SA_W-1:0];
  assign last_pix = (h_r == high_r) && (v_r == higv_r);

  always_comb begin
    h_nxt = h_r + ONE_C;
    v_nxt = v_r;
    row_base_nxt = row_base_r;
    if (h_r == high_r) begin
      h_nxt = lowh_r;
      v_nxt = v_r + ONE_C;
      row_base_nxt = row_base_r + 32'(frame_width);
    end
  end

  // Weighted offsets of the pixel read on the previous cycle.
  assign pcx = $signed({1'b0, rd_data_r}) * (ph_r - h0_r);
  assign pcy = $signed({1'b0, rd_data_r}) * (pv_row_r - v0_r);

  // Divider state: two restoring dividers sharing the weight.
  logic [NUM_W-1:0] nx_r, ny_r;
  logic [WT_W:0]    remx_r, remy_r;
  logic             negx_r, negy_r;
  logic [QCNT_W-1:0] qcnt_r;
  logic [WT_W:0]    tx, ty;
  logic [MOM_W-1:0] absx, absy;

  assign absx = cm_r[MOM_W-1] ? MOM_W'(-cm_r) : MOM_W'(cm_r);
  assign absy = rm_r[MOM_W-1] ? MOM_W'(-rm_r) : MOM_W'(rm_r);
  assign tx = {remx_r[WT_W-1:0], nx_r[NUM_W-1]};
  assign ty = {remy_r[WT_W-1:0], ny_r[NUM_W-1]};

  always_ff @(posedge clk) begin
    pv_r <= 1'b0;
    if (cmd.load) begin
      h0_r   <= $signed(CRD_W'(spot_x >> FRAC_BITS));
      v0_r   <= $signed(CRD_W'(spot_y >> FRAC_BITS));
      lowh_r <= lh;
      high_r <= hh;
      higv_r <= hv;
      h_r    <= lh;
      v_r    <= lv;
      row_base_r <= 32'($unsigned(lv)) * 32'(frame_width);
      cm_r <= '0;
      rm_r <= '0;
      wt_r <= WT_W'(1);
    end
    if (cmd.acc) begin
      h_r <= h_nxt;
      v_r <= v_nxt;
      row_base_r <= row_base_nxt;
      pv_r <= in_store;
      ph_r <= h_r;
      pv_row_r <= v_r;
    end
    // Accumulate the pixel read on the previous cycle.
    if (pv_r) begin
      cm_r <= cm_r + MOM_W'(pcx);
      rm_r <= rm_r + MOM_W'(pcy);
      wt_r <= wt_r + WT_W'(rd_data_r);
    end
    if (cmd.div_start) begin
      nx_r <= {absx, {FRAC_BITS{1'b0}}};
      ny_r <= {absy, {FRAC_BITS{1'b0}}};
      negx_r <= cm_r[MOM_W-1];
      negy_r <= rm_r[MOM_W-1];
      remx_r <= '0;
      remy_r <= '0;
      qcnt_r <= '0;
    end
    if (cmd.div_step) begin
      qcnt_r <= qcnt_r + 1'b1;
      if (tx >= {1'b0, wt_r}) begin
        remx_r <= tx - {1'b0, wt_r};
        nx_r   <= {nx_r[NUM_W-2:0], 1'b1};
      end else begin
        remx_r <= tx;
        nx_r   <= {nx_r[NUM_W-2:0], 1'b0};
      end
      if (ty >= {1'b0, wt_r}) begin
        remy_r <= ty - {1'b0, wt_r};
        ny_r   <= {ny_r[NUM_W-2:0], 1'b1};
      end else begin
        remy_r <= ty;
        ny_r   <= {ny_r[NUM_W-2:0], 1'b0};
      end
    end
  end

  // Result: center plus signed quotient, clamped at zero, low bits kept.
  logic signed [NUM_W+1:0] qx, qy, rx, ry;
  always_comb begin
    qx = negx_r ? -$signed({2'b00, nx_r}) : $signed({2'b00, nx_r});
    qy = negy_r ? -$signed({2'b00, ny_r}) : $signed({2'b00, ny_r});
    rx = ($signed((NUM_W+2)'(h0_r)) <<< FRAC_BITS) + qx;
    ry = ($signed((NUM_W+2)'(v0_r)) <<< FRAC_BITS) + qy;
    if (rx < 0) rx = '0;
    if (ry < 0) ry = '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_x <= rx[POS_W-1:0];
      res_y <= ry[POS_W-1:0];
    end
  end

  assign sts.win_done  = last_pix;
  assign sts.win_empty = (lh > hh) || (lv > hv);
  assign sts.div_done  = (qcnt_r == QCNT_W'(NUM_W - 1));

endmodule

// ===== src/wsc_ctrl.sv =====
// Controller state machine for the windowed spot centroid unit.
module wsc_ctrl
  import wsc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     in_query,
  input  logic     in_skip,
  input  logic     out_free,
  input  wsc_sts_t sts,
  output wsc_cmd_t cmd,
  output logic     busy,
  output logic     emit_skip,
  output logic     emit_calc
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ACC   = 7'b0000010,
    S_DRAIN = 7'b0000100,
    S_PREP  = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Sequencing of window walk, division and result hand-off.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    emit_skip = 1'b0;
    emit_calc = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_query) begin
          if (in_skip) emit_skip = 1'b1;
          else begin
            cmd.load = 1'b1;
            state_nxt = sts.win_empty ? S_PREP : S_ACC;
          end
        end
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (sts.win_done) state_nxt = S_DRAIN;
      end
      // The last window pixel is added to the sums in this cycle.
      S_DRAIN: begin
        state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          emit_calc = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== src/windowed_spot_centroid_unit.sv =====
// Top level of the windowed spot centroid unit.
//
// A frame of pixels is loaded by write items (in_tuser opcode 0) on the in_
// stream; each write goes straight to the frame memory and gives no result.
// A query item (opcode 1) returns one result on the out_ stream. A skipped
// query is passed straight to the output register, its position unchanged.
// Otherwise the controller walks the clipped square window one pixel a cycle
// through the single read port of the frame memory, waits in a drain state
// for the last pixel to reach the sums, then runs two restoring dividers,
// each producing one quotient bit a cycle until all 56 bits are formed. The
// memory read port sets the walk, the dividers the tail. One item is in
// flight at a time. Results sit in an output register; while it holds a
// result and the receiver stalls, in_tready stays low. Reset returns the
// registers to width 512, height 512, radius 4; frame contents are
// undefined until written. Configuration writes are taken every cycle.
module windowed_spot_centroid_unit
  import wsc_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int PIXEL_BITS = 16,
  parameter int FRAC_BITS  = 8,
  parameter int MAX_RADIUS = 63
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: pixel_addr, pixel_value, spot_x, spot_y, skip_flag (69 bits + pad)
  input  logic [71:0] in_tdata,
  input  logic        in_tuser,   // opcode
  input  logic        in_tlast,   // last_spot
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: out_x, out_y (34 bits + pad)
  output logic [39:0] out_tdata,
  output logic        out_tlast,  // last_result
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [DIM_W-1:0] width_r, height_r;
  logic [RAD_W-1:0] radius_r;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(512);
      height_r <= DIM_W'(512);
      radius_r <= RAD_W'(4);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[DIM_W-1:0];
        REG_RADIUS: radius_r <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack input fields.
  logic               f_op, f_skip;
  logic [ADDR_W-1:0]  f_addr;
  logic [VAL_W-1:0]   f_val;
  logic [POS_W-1:0]   f_x, f_y;
  assign f_op   = in_tuser;
  assign f_addr = in_tdata[17:0];
  assign f_val  = in_tdata[33:18];
  assign f_x    = in_tdata[50:34];
  assign f_y    = in_tdata[67:51];
  assign f_skip = in_tdata[68];

  wsc_cmd_t cmd;
  wsc_sts_t sts;
  logic busy, emit_skip, emit_calc, in_fire, out_free;
  logic [POS_W-1:0] res_x, res_y;
  logic last_q_r;

  // Output register; free when empty or being taken this cycle.
  logic ov_r;
  assign out_free  = !ov_r || out_tready;
  assign in_tready = !busy && out_free;
  assign in_fire   = in_tvalid && in_tready;

  wsc_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .in_query(f_op == OP_QUERY), .in_skip(f_skip),
    .out_free, .sts, .cmd, .busy, .emit_skip, .emit_calc
  );

  wsc_datapath #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .PIXEL_BITS(PIXEL_BITS),
    .FRAC_BITS(FRAC_BITS), .MAX_RADIUS(MAX_RADIUS)
  ) u_dp (
    .clk, .wr_en(in_fire && f_op == OP_WRITE), .wr_addr(f_addr), .wr_value(f_val),
    .spot_x(f_x), .spot_y(f_y), .frame_width(width_r), .frame_height(height_r),
    .radius(radius_r), .cmd, .sts, .res_x, .res_y
  );

  // Result transfer register.
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (emit_skip || emit_calc) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
    if (cmd.load) last_q_r <= in_tlast;
    if (emit_skip) begin
      out_tdata <= {6'd0, f_y, f_x};
      out_tlast <= in_tlast;
    end else if (emit_calc) begin
      out_tdata <= {6'd0, res_y, res_x};
      out_tlast <= last_q_r;
    end
  end
  assign out_tvalid = ov_r;

endmodule
